### src/emp_pkg.sv
// shared types, constants and register codes for the energy meter pulse output
`timescale 1ns / 1ps
package emp_pkg;

  localparam int TIME_W    = 32;
  localparam int POWER_W   = 16;
  localparam int MAG_W     = POWER_W + 1;
  localparam int ENERGY_W  = 48;
  localparam int QUANT_W   = 32;
  localparam int WIDTH_W   = 16;
  localparam int COUNT_W   = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = $clog2(ENERGY_W);

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX            = '1;
  localparam logic [QUANT_W-1:0] ENERGY_PER_PULSE_RST = 32'd3600000;
  localparam logic [WIDTH_W-1:0] PULSE_WIDTH_RST      = 16'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENERGY_PER_PULSE = 1'b0,
    CFG_PULSE_WIDTH      = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC,
    BK_SEL,
    BK_DIV,
    BK_CNT,
    BK_SERVE,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [TIME_W-1:0]         time_ms;
    logic signed [POWER_W-1:0] net_power_w;
  } in_t;

  typedef struct packed {
    logic               import_led;
    logic               export_led;
    logic [COUNT_W-1:0] import_pending;
    logic [COUNT_W-1:0] export_pending;
  } out_t;

  typedef struct packed {
    logic [QUANT_W-1:0] energy_per_pulse;
    logic [WIDTH_W-1:0] pulse_len;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] dt;
    logic [MAG_W-1:0]  mag;
    logic              neg;
    logic              first;
  } item_t;

  typedef struct packed {
    logic               active;
    logic [TIME_W-1:0]  off_time;
    logic [COUNT_W-1:0] count;
  } chan_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

### src/energy_meter_pulse_output.sv
// top level of the energy meter pulse output: config registers, front, queue, back
//
//   channel  handshake                   payload
//   in       in_valid / in_ready         in_data   (time_ms, net_power_w)
//   out      out_valid / out_ready       out_data  (leds, pending counts)
//   cfg      cfg_we                      cfg_index, cfg_data
//
// one beat at a time in the back end, with a divide pass for each accumulator
// holding at least one energy quantum (48-step radix-2 divider, one bit a cycle)
// the first beat after reset skips the multiply and accumulate steps
// the queue takes new beats while the back end works; the result register
// lets the back end start the next beat while a result waits
// synchronous reset clears all energy, counts and pulses and reloads the config defaults
`timescale 1ns / 1ps
module energy_meter_pulse_output #(
  parameter int QUEUE_DEPTH = emp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  emp_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output emp_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [emp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [emp_pkg::CFG_W-1:0]     cfg_data
);

  emp_pkg::cfg_t          cfg;
  emp_pkg::queue_status_t q_status;
  emp_pkg::item_t         push_item;
  emp_pkg::item_t         pop_item;
  logic                   q_push;
  logic                   q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.energy_per_pulse <= emp_pkg::ENERGY_PER_PULSE_RST;
      cfg.pulse_len        <= emp_pkg::PULSE_WIDTH_RST;
    end else if (cfg_we) begin
      case (emp_pkg::cfg_reg_e'(cfg_index))
        emp_pkg::CFG_ENERGY_PER_PULSE: begin
          cfg.energy_per_pulse <= cfg_data[emp_pkg::QUANT_W-1:0];
        end
        emp_pkg::CFG_PULSE_WIDTH: begin
          cfg.pulse_len <= cfg_data[emp_pkg::WIDTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  emp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  emp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  emp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_status.valid)
    else $error("back end popped an empty queue");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> q_status.valid)
    else $error("accepted beat missing from queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

### src/emp_front.sv
// front end: takes input beats, tracks elapsed time and classifies power sign
`timescale 1ns / 1ps
module emp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  emp_pkg::in_t           in_data,
  input  emp_pkg::queue_status_t q_status,
  output logic                   q_push,
  output emp_pkg::item_t         q_item
);

  logic                       started;
  logic [emp_pkg::TIME_W-1:0] last_time;
  logic [emp_pkg::POWER_W-1:0] raw;

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && in_ready;
  assign raw      = in_data.net_power_w;

  always_comb begin
    q_item.now   = in_data.time_ms;
    q_item.dt    = in_data.time_ms - last_time;
    q_item.neg   = raw[emp_pkg::POWER_W-1];
    q_item.mag   = q_item.neg ? (emp_pkg::MAG_W'(0) - emp_pkg::MAG_W'(signed'(raw)))
                              : emp_pkg::MAG_W'(raw);
    q_item.first = !started;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      last_time <= '0;
    end else if (q_push) begin
      started   <= 1'b1;
      last_time <= in_data.time_ms;
    end
  end

endmodule

### src/emp_fifo.sv
// short queue between the front end and the back end
`timescale 1ns / 1ps
module emp_fifo #(
  parameter int DEPTH = emp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  emp_pkg::item_t         push_item,
  input  logic                   pop,
  output emp_pkg::item_t         pop_item,
  output emp_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  emp_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign pop_item     = mem[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full  = (count == CNT_FULL);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### src/emp_back.sv
// back end: integrates energy, divides out quanta, drives pulses and the result register
`timescale 1ns / 1ps
module emp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  emp_pkg::cfg_t          cfg,
  input  emp_pkg::queue_status_t q_status,
  input  emp_pkg::item_t         q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output emp_pkg::out_t          out_data
);

  localparam int EW = emp_pkg::ENERGY_W;
  localparam int QW = emp_pkg::QUANT_W;
  localparam logic [emp_pkg::DIV_CNT_W-1:0] DIV_LAST = emp_pkg::DIV_CNT_W'(EW - 1);

  function automatic emp_pkg::chan_t serve(
    input emp_pkg::chan_t               c,
    input logic [emp_pkg::TIME_W-1:0]   now,
    input logic [emp_pkg::WIDTH_W-1:0]  width
  );
    emp_pkg::chan_t             r;
    logic [emp_pkg::TIME_W-1:0] diff;
    r = c;
    if (!r.active && r.count != '0) begin
      r.active   = 1'b1;
      r.off_time = now + emp_pkg::TIME_W'(width);
      r.count    = r.count - emp_pkg::COUNT_W'(1);
    end
    diff = now - r.off_time;
    if (r.active && !diff[emp_pkg::TIME_W-1]) begin
      r.active = 1'b0;
    end
    return r;
  endfunction

  emp_pkg::back_state_e state, state_next;
  emp_pkg::item_t       item, item_next;
  logic [EW-1:0]        prod, prod_next;
  logic [EW-1:0]        imp_energy, imp_energy_next;
  logic [EW-1:0]        exp_energy, exp_energy_next;
  emp_pkg::chan_t       imp_ch, imp_ch_next;
  emp_pkg::chan_t       exp_ch, exp_ch_next;
  logic                 sel, sel_next;
  logic [QW-1:0]        rem, rem_next;
  logic [EW-1:0]        dvd, dvd_next;
  logic [emp_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;
  emp_pkg::out_t        out_data_next;

  logic [QW-1:0]                q_eff;
  logic [EW-1:0]                cur_energy;
  logic [emp_pkg::COUNT_W-1:0]  cur_count;
  logic [EW:0]                  prod_full;
  logic [QW:0]                  rem_sh;
  logic [QW:0]                  rem_sub;
  logic                         rem_ge;
  logic [EW:0]                  qsum;
  logic [emp_pkg::COUNT_W-1:0]  count_new;
  logic                         out_free;

  assign q_eff      = (cfg.energy_per_pulse == '0) ? QW'(1) : cfg.energy_per_pulse;
  assign cur_energy = sel ? exp_energy : imp_energy;
  assign cur_count  = sel ? exp_ch.count : imp_ch.count;
  assign prod_full  = item.mag * item.dt;
  assign rem_sh     = {rem, dvd[EW-1]};
  assign rem_sub    = rem_sh - {1'b0, q_eff};
  assign rem_ge     = (rem_sh >= {1'b0, q_eff});
  assign qsum       = (EW+1)'(cur_count) + {1'b0, dvd};
  assign count_new  = (qsum > (EW+1)'(emp_pkg::COUNT_MAX)) ? emp_pkg::COUNT_MAX
                                                             : qsum[emp_pkg::COUNT_W-1:0];
  assign out_free   = !out_valid || out_ready;
  assign q_pop      = (state == emp_pkg::BK_IDLE) && q_status.valid;

  always_comb begin
    state_next      = state;
    item_next       = item;
    prod_next       = prod;
    imp_energy_next = imp_energy;
    exp_energy_next = exp_energy;
    imp_ch_next     = imp_ch;
    exp_ch_next     = exp_ch;
    sel_next        = sel;
    rem_next        = rem;
    dvd_next        = dvd;
    div_cnt_next    = div_cnt;
    out_valid_next  = out_valid && !out_ready;
    out_data_next   = out_data;
    case (state)
      emp_pkg::BK_IDLE: begin
        if (q_status.valid) begin
          item_next  = q_item;
          sel_next   = 1'b0;
          state_next = q_item.first ? emp_pkg::BK_SEL : emp_pkg::BK_MUL;
        end
      end
      emp_pkg::BK_MUL: begin
        prod_next  = prod_full[EW-1:0];
        state_next = emp_pkg::BK_ACC;
      end
      emp_pkg::BK_ACC: begin
        if (item.neg) begin
          exp_energy_next = exp_energy + prod;
        end else begin
          imp_energy_next = imp_energy + prod;
        end
        state_next = emp_pkg::BK_SEL;
      end
      emp_pkg::BK_SEL: begin
        if (cur_energy < EW'(q_eff)) begin
          sel_next   = 1'b1;
          state_next = sel ? emp_pkg::BK_SERVE : emp_pkg::BK_SEL;
        end else begin
          rem_next     = '0;
          dvd_next     = cur_energy;
          div_cnt_next = '0;
          state_next   = emp_pkg::BK_DIV;
        end
      end
      emp_pkg::BK_DIV: begin
        rem_next     = rem_ge ? rem_sub[QW-1:0] : rem_sh[QW-1:0];
        dvd_next     = {dvd[EW-2:0], rem_ge};
        div_cnt_next = div_cnt + emp_pkg::DIV_CNT_W'(1);
        if (div_cnt == DIV_LAST) begin
          state_next = emp_pkg::BK_CNT;
        end
      end
      emp_pkg::BK_CNT: begin
        if (sel) begin
          exp_energy_next   = EW'(rem);
          exp_ch_next.count = count_new;
          state_next        = emp_pkg::BK_SERVE;
        end else begin
          imp_energy_next   = EW'(rem);
          imp_ch_next.count = count_new;
          state_next        = emp_pkg::BK_SEL;
        end
        sel_next = 1'b1;
      end
      emp_pkg::BK_SERVE: begin
        imp_ch_next = serve(imp_ch, item.now, cfg.pulse_len);
        exp_ch_next = serve(exp_ch, item.now, cfg.pulse_len);
        state_next  = emp_pkg::BK_DONE;
      end
      emp_pkg::BK_DONE: begin
        if (out_free) begin
          out_valid_next               = 1'b1;
          out_data_next.import_led     = imp_ch.active;
          out_data_next.export_led     = exp_ch.active;
          out_data_next.import_pending = imp_ch.count;
          out_data_next.export_pending = exp_ch.count;
          state_next                   = emp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = emp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= emp_pkg::BK_IDLE;
      imp_energy <= '0;
      exp_energy <= '0;
      imp_ch     <= '0;
      exp_ch     <= '0;
      sel        <= 1'b0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      imp_energy <= imp_energy_next;
      exp_energy <= exp_energy_next;
      imp_ch     <= imp_ch_next;
      exp_ch     <= exp_ch_next;
      sel        <= sel_next;
      div_cnt    <= div_cnt_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    prod     <= prod_next;
    rem      <= rem_next;
    dvd      <= dvd_next;
    out_data <= out_data_next;
  end

endmodule

### sim/tb_top.sv
// testbench for the energy meter pulse output: directed and random beats checked by a predictor
`timescale 1ns / 1ps
module tb_top;

  localparam int GAP_PERCENT    = 21;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 3000;

  class meter_scoreboard;
    localparam int CH_IMPORT = 0;
    localparam int CH_EXPORT = 1;
    localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;

    logic [emp_pkg::QUANT_W-1:0] quantum;
    logic [emp_pkg::WIDTH_W-1:0] width_ms;
    bit                          started;
    logic [emp_pkg::TIME_W-1:0]  last_ms;
    logic [63:0]                 energy [2];
    int unsigned                 pending [2];
    bit                          led [2];
    logic [emp_pkg::TIME_W-1:0]  off_ms [2];
    emp_pkg::out_t               expected_q [$];
    int                          errors;
    int                          checked;
    int                          beats;
    int                          lit;

    function new();
      quantum  = emp_pkg::ENERGY_PER_PULSE_RST;
      width_ms = emp_pkg::PULSE_WIDTH_RST;
      started  = 1'b0;
      last_ms  = '0;
      for (int ch = 0; ch < 2; ch++) begin
        energy[ch]  = '0;
        pending[ch] = 0;
        led[ch]     = 1'b0;
        off_ms[ch]  = '0;
      end
      errors  = 0;
      checked = 0;
      beats   = 0;
      lit     = 0;
    endfunction

    function void set_registers(logic [emp_pkg::QUANT_W-1:0] q,
                                logic [emp_pkg::WIDTH_W-1:0] w);
      quantum  = q;
      width_ms = w;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // integrate one sample, move whole quanta to the pending counts, then run the lamps
    function void note_beat(emp_pkg::in_t b);
      logic [15:0]                raw;
      logic [emp_pkg::TIME_W-1:0] now;
      logic [emp_pkg::TIME_W-1:0] dt;
      logic [emp_pkg::TIME_W-1:0] since_off;
      logic [63:0]                mag;
      logic [63:0]                q;
      logic [63:0]                quanta;
      logic [63:0]                total;
      bit                         neg;
      emp_pkg::out_t              r;
      now = b.time_ms;
      raw = b.net_power_w;
      neg = raw[15];
      mag = neg ? (64'h10000 - 64'(raw)) : 64'(raw);
      if (!started) begin
        started = 1'b1;
        last_ms = now;
      end else begin
        dt = now - last_ms;
        last_ms = now;
        energy[neg] = (energy[neg] + mag * 64'(dt)) & MASK48;
      end
      q = (quantum == '0) ? 64'd1 : 64'(quantum);
      for (int ch = 0; ch < 2; ch++) begin
        quanta = energy[ch] / q;
        energy[ch] = energy[ch] - quanta * q;
        total = 64'(pending[ch]) + quanta;
        pending[ch] = (total > 64'(emp_pkg::COUNT_MAX)) ? 32'(emp_pkg::COUNT_MAX)
                                                         : 32'(total);
        if (!led[ch] && pending[ch] != 0) begin
          led[ch] = 1'b1;
          off_ms[ch] = now + 32'(width_ms);
          pending[ch] = pending[ch] - 1;
        end
        since_off = now - off_ms[ch];
        if (led[ch] && !since_off[31]) led[ch] = 1'b0;
      end
      r.import_led     = led[CH_IMPORT];
      r.export_led     = led[CH_EXPORT];
      r.import_pending = 16'(pending[CH_IMPORT]);
      r.export_pending = 16'(pending[CH_EXPORT]);
      expected_q.push_back(r);
      beats++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(emp_pkg::out_t got);
      emp_pkg::out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.import_led || got.export_led) lit++;
      compare_field("import_led", 16'(want.import_led), 16'(got.import_led));
      compare_field("export_led", 16'(want.export_led), 16'(got.export_led));
      compare_field("import_pending", want.import_pending, got.import_pending);
      compare_field("export_pending", want.export_pending, got.export_pending);
    endfunction
  endclass

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  emp_pkg::in_t                  in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  emp_pkg::out_t                 out_data;
  logic                          cfg_we    = 1'b0;
  logic [emp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [emp_pkg::CFG_W-1:0]     cfg_data  = '0;

  meter_scoreboard            sb;
  bit                         gaps_on    = 1'b1;
  bit                         rx_hold    = 1'b0;
  bit                         power_neg  = 1'b0;
  logic [emp_pkg::TIME_W-1:0] meter_time = '0;
  int                         settings_loaded = 1;
  int                         idle_cycles = 0;

  energy_meter_pulse_output i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_beat(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver with random stalls and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      out_ready <= !(gaps_on && $urandom_range(99) < GAP_PERCENT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input emp_pkg::in_t b);
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_at(input logic [emp_pkg::TIME_W-1:0] t,
                         input logic [emp_pkg::POWER_W-1:0] p);
    emp_pkg::in_t b;
    meter_time    = t;
    b.time_ms     = t;
    b.net_power_w = p;
    send_beat(b);
  endtask

  // sign runs with random size, some zero, extreme and raw noise samples
  task automatic send_random(input int unsigned max_dt);
    logic [emp_pkg::POWER_W-1:0] p;
    logic [emp_pkg::POWER_W-1:0] mag;
    int unsigned                 pick;
    if ($urandom_range(7) == 0) power_neg = !power_neg;
    pick = $urandom_range(19);
    if (pick == 0) begin
      mag = '0;
    end else if (pick < 3) begin
      mag = power_neg ? 16'h8000 : 16'h7FFF;
    end else begin
      mag = emp_pkg::POWER_W'($urandom_range(power_neg ? 32768 : 32767, 1));
    end
    p = power_neg ? (16'h0 - mag) : mag;
    if (pick == 3) p = emp_pkg::POWER_W'($urandom);
    send_at(meter_time + $urandom_range(max_dt), p);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic load_settings(input logic [emp_pkg::QUANT_W-1:0] q,
                               input logic [emp_pkg::WIDTH_W-1:0] w);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= emp_pkg::CFG_ENERGY_PER_PULSE;
    cfg_data  <= q;
    @(posedge clk);
    cfg_index <= emp_pkg::CFG_PULSE_WIDTH;
    cfg_data  <= emp_pkg::CFG_W'(w);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_registers(q, w);
    settings_loaded++;
  endtask

  initial begin
    logic [emp_pkg::TIME_W-1:0] t;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first sample, forward wrap, power extremes, lamp on and off
    send_at(32'hFFFF_FFF0, 16'h7FFF);
    send_at(32'hFFFF_FFFF, 16'h7FFF);
    send_at(32'h0000_0000, 16'h8000);
    send_at(32'd110, 16'h7FFF);
    send_at(32'd120, 16'h0000);
    send_at(32'd130, 16'hFFFF);
    send_at(32'd131, 16'h7FFF);
    send_at(32'd240, 16'h7FFF);
    send_at(32'd250, 16'h8000);
    send_at(32'd360, 16'h8000);
    send_at(32'd370, 16'h7FFF);
    send_at(32'd379, 16'h0000);
    send_at(32'd380, 16'h0000);
    send_at(32'h7FFF_FFFF, 16'h0000);
    send_at(32'h8000_0000, 16'h0001);

    repeat (60) send_random(40);
    rx_hold = 1'b1;
    repeat (90) send_random(40);

    load_settings(32'd100000, 16'd1);
    gaps_on = 1'b0;
    repeat (150) send_random(5);
    gaps_on = 1'b1;

    load_settings($urandom_range(32'h7FFF_FFFF, 1000000),
                  emp_pkg::WIDTH_W'($urandom_range(200, 1)));
    repeat (100) send_random(300);
    wait_drained();
    repeat (100) send_random(300);

    load_settings(32'd50000, 16'hFFFF);
    repeat (100) send_random(100);

    // largest quantum: backward time steps and count saturation
    load_settings(32'hFFFF_FFFF, 16'hFFFF);
    t = meter_time;
    send_at(t - 32'd1, 16'h0001);
    send_at(t - 32'd2, 16'h8000);
    send_at(t - 32'd3, 16'h8000);
    send_at(t - 32'd4, 16'h7FFF);
    send_at(t - 32'd5, 16'h7FFF);
    send_at(t - 32'd6, 16'h7FFF);
    send_at(t - 32'd7, 16'h0000);
    repeat (80) send_random(32'hFFFF_FFFF);

    load_settings(32'd1, 16'd0);
    repeat (30) send_random(50);

    load_settings(32'd0, 16'd1);
    repeat (10) send_random(50);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d beats over %0d register settings, %0d results checked, %0d with a lamp lit",
             sb.beats, settings_loaded, sb.checked, sb.lit);
    $display("covered time wrap, count saturation, zero quantum and zero width, long hold-off");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
